>>> hw/rtl/kge_pkg.sv
// shared types and constants for the kneser graph edge generator
// used by kge_ctrl, kge_datapath, kge_succ and the top level
`default_nettype none

package kge_pkg;

  // widths fixed by the register map and the result fields
  localparam int CFG_W = 5;
  localparam int OUT_W = 14;

  // register indexes
  localparam logic REG_N_ELEMENTS  = 1'b0;
  localparam logic REG_SUBSET_SIZE = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] N_RESET = 5'd4;
  localparam logic [CFG_W-1:0] K_RESET = 5'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PASCAL,
    ST_INIT_INNER,
    ST_SCAN,
    ST_WRAP_OUTER,
    ST_WRAP_INNER,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic restart;
    logic pascal_step;
    logic pascal_load;
    logic init_inner;
    logic scan_step;
    logic wrap_outer;
    logic wrap_inner;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_now;
    logic pascal_end;
    logic finished;
    logic hit;
    logic disjoint;
    logic inner_wrap;
    logic finishing;
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/kneser_graph_edge_generator.sv
// top level of the kneser graph K(n,k) edge generator
// holds the config registers, joins kge_ctrl and kge_datapath; uses kge_pkg
//
//   channel | direction | handshake             | beat contents
//   --------+-----------+-----------------------+---------------------------------------
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//   in      | in        | in_valid / in_ready   | restart
//   out     | out       | out_valid / out_ready | first_vertex, second_vertex, edge_valid,
//           |           |                       | vertex_count, bad_config
//
// a restart beat with a good config adds a pascal sweep and the ST_INIT_INNER setup state
// each request then tests one vertex pair per cycle through the shared successor unit;
// stepping the outer subset passes through ST_WRAP_OUTER and ST_WRAP_INNER, and ST_EMIT loads the result
// reset gives n=4, k=2 and an exhausted enumeration until the first restart
// the result register frees the scan; a stalled result holds only the final load
`default_nettype none

module kneser_graph_edge_generator #(
  parameter int MAX_ELEMENTS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [kge_pkg::CFG_W-1:0]   cfg_data,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        restart,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [kge_pkg::OUT_W-1:0]        first_vertex,
  output logic [kge_pkg::OUT_W-1:0]        second_vertex,
  output logic                             edge_valid,
  output logic [kge_pkg::OUT_W-1:0]        vertex_count,
  output logic                             bad_config
);

  logic [kge_pkg::CFG_W-1:0] n_elements, subset_size;
  kge_pkg::cmd_t             cmd;
  kge_pkg::sts_t             sts;

  // config writes are always taken; they only matter at the next restart
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_elements  <= kge_pkg::N_RESET;
      subset_size <= kge_pkg::K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kge_pkg::REG_N_ELEMENTS:  n_elements  <= cfg_data;
        kge_pkg::REG_SUBSET_SIZE: subset_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  kge_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .restart   (restart),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // masks, indices, vertex count and the result register
  kge_datapath #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_n         (n_elements),
    .cfg_k         (subset_size),
    .cmd           (cmd),
    .sts           (sts),
    .first_vertex  (first_vertex),
    .second_vertex (second_vertex),
    .edge_valid    (edge_valid),
    .vertex_count  (vertex_count),
    .bad_config    (bad_config)
  );

`ifndef SYNTHESIS
  // an accepted request always takes the block out of the idle state in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while still idle next cycle");

  // a bad configuration never yields an edge
  a_bad_no_edge: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_config) |-> (!edge_valid && vertex_count == '0))
    else $error("edge or count reported on bad configuration");

  // edges come in i<j order
  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && edge_valid) |-> ((MAX_ELEMENTS > 16) || (first_vertex < second_vertex)))
    else $error("edge not in ascending vertex order");

  // an edge needs at least two vertices
  a_edge_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && edge_valid) |-> ((MAX_ELEMENTS > 16) || (second_vertex < vertex_count)))
    else $error("edge vertex beyond vertex count");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/kge_succ.sv
// lexicographic successor of a k-subset held as a bit mask over n elements
// uses kge_pkg for the element count width
`default_nettype none

module kge_succ #(
  parameter int MAX_ELEMENTS = 16
) (
  input  wire logic [MAX_ELEMENTS-1:0]     mask,
  input  wire logic [kge_pkg::CFG_W-1:0]   n,
  output logic      [MAX_ELEMENTS-1:0]     nxt
);

  always_comb begin
    logic [MAX_ELEMENTS-1:0] full;
    logic [MAX_ELEMENTS-1:0] sz;
    logic [MAX_ELEMENTS-1:0] below;
    logic [MAX_ELEMENTS-1:0] sp;
    logic [MAX_ELEMENTS-1:0] top_h;
    logic [MAX_ELEMENTS-1:0] top_p;
    logic [MAX_ELEMENTS-1:0] keep;
    logic [MAX_ELEMENTS-1:0] run;
    logic [kge_pkg::CFG_W-1:0] h;
    logic [kge_pkg::CFG_W-1:0] p;
    logic [kge_pkg::CFG_W:0]   hi;

    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      full[i] = kge_pkg::CFG_W'(i) < n;
    end

    // smear the free positions downward: bits at and below the highest hole
    sz = ~mask & full;
    for (int s = 1; s < MAX_ELEMENTS; s = s * 2) begin
      sz = sz | (sz >> s);
    end

    // elements below the hole, the highest of them is the one that moves
    below = mask & sz;
    sp = below;
    for (int s = 1; s < MAX_ELEMENTS; s = s * 2) begin
      sp = sp | (sp >> s);
    end

    top_h = sz & ~(sz >> 1);
    top_p = sp & ~(sp >> 1);
    h = '0;
    p = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (top_h[i]) h = h | kge_pkg::CFG_W'(i);
      if (top_p[i]) p = p | kge_pkg::CFG_W'(i);
    end

    // moved element plus the packed run above it lands on p+1 .. n+p-h
    hi = {1'b0, n} + {1'b0, p} + (kge_pkg::CFG_W+1)'(1) - {1'b0, h};
    keep = mask & (sp >> 1);
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      run[i] = ((kge_pkg::CFG_W+1)'(i) < hi) && (kge_pkg::CFG_W'(i) > p);
    end

    nxt = (below == '0) ? mask : (keep | run);
  end

endmodule

`default_nettype wire

>>> hw/rtl/kge_ctrl.sv
// sequencer for the edge generator: restart, pascal sweep, pair scan, emit
// uses kge_pkg state, command and status types
`default_nettype none

module kge_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic           restart,
  output logic                in_ready,
  input  wire logic           out_ready,
  output logic                out_valid,
  input  wire kge_pkg::sts_t  sts,
  output kge_pkg::cmd_t       cmd
);

  kge_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kge_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == kge_pkg::ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      kge_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (restart) begin
            cmd.restart = 1'b1;
            state_next  = sts.bad_now ? kge_pkg::ST_SCAN : kge_pkg::ST_PASCAL;
          end else begin
            state_next = kge_pkg::ST_SCAN;
          end
        end
      end
      kge_pkg::ST_PASCAL: begin
        if (sts.pascal_end) begin
          cmd.pascal_load = 1'b1;
          state_next      = kge_pkg::ST_INIT_INNER;
        end else begin
          cmd.pascal_step = 1'b1;
        end
      end
      kge_pkg::ST_INIT_INNER: begin
        cmd.init_inner = 1'b1;
        state_next     = kge_pkg::ST_SCAN;
      end
      kge_pkg::ST_SCAN: begin
        if (sts.finished) begin
          state_next = kge_pkg::ST_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.inner_wrap && !sts.finishing) begin
            state_next = kge_pkg::ST_WRAP_OUTER;
          end else if (sts.disjoint) begin
            state_next = kge_pkg::ST_EMIT;
          end
        end
      end
      kge_pkg::ST_WRAP_OUTER: begin
        cmd.wrap_outer = 1'b1;
        state_next     = kge_pkg::ST_WRAP_INNER;
      end
      kge_pkg::ST_WRAP_INNER: begin
        cmd.wrap_inner = 1'b1;
        state_next     = sts.hit ? kge_pkg::ST_EMIT : kge_pkg::ST_SCAN;
      end
      kge_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = kge_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kge_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/kge_datapath.sv
// datapath: latched config, pascal row for C(n,k), subset masks, indices, result beat
// uses kge_pkg types and kge_succ
`default_nettype none

module kge_datapath #(
  parameter int MAX_ELEMENTS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [kge_pkg::CFG_W-1:0]   cfg_n,
  input  wire logic [kge_pkg::CFG_W-1:0]   cfg_k,
  input  wire kge_pkg::cmd_t               cmd,
  output kge_pkg::sts_t                    sts,
  output logic [kge_pkg::OUT_W-1:0]        first_vertex,
  output logic [kge_pkg::OUT_W-1:0]        second_vertex,
  output logic                             edge_valid,
  output logic [kge_pkg::OUT_W-1:0]        vertex_count,
  output logic                             bad_config
);

  localparam int CNT_W = MAX_ELEMENTS;
  localparam int RW    = $clog2(MAX_ELEMENTS + 1);
  localparam int EXT_W = (CNT_W > kge_pkg::OUT_W) ? CNT_W : kge_pkg::OUT_W;

  logic [kge_pkg::CFG_W-1:0] lat_n, lat_k, pcnt;
  logic                      lat_bad;
  logic [CNT_W-1:0]          row [MAX_ELEMENTS+1];
  logic [CNT_W-1:0]          vertex_total;
  logic [MAX_ELEMENTS-1:0]   outer_mask, inner_mask;
  logic [CNT_W-1:0]          outer_index, inner_index;
  logic                      finished, hit;
  logic [CNT_W-1:0]          hit_a, hit_b;

  logic [MAX_ELEMENTS-1:0]   succ_in, succ_out, low_k;
  logic [CNT_W-1:0]          row_k;
  logic [EXT_W-1:0]          a_ext, b_ext, total_ext;

  assign succ_in = cmd.scan_step ? inner_mask : outer_mask;

  kge_succ #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_succ (
    .mask (succ_in),
    .n    (lat_n),
    .nxt  (succ_out)
  );

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      low_k[i] = kge_pkg::CFG_W'(i) < lat_k;
    end
  end

  assign row_k = row[lat_k[RW-1:0]];

  assign sts.bad_now    = (cfg_k > cfg_n) || (cfg_n > kge_pkg::CFG_W'(MAX_ELEMENTS));
  assign sts.pascal_end = (pcnt == lat_n);
  assign sts.finished   = finished;
  assign sts.hit        = hit;
  assign sts.disjoint   = ((outer_mask & inner_mask) == '0);
  assign sts.inner_wrap = ({1'b0, inner_index} + (CNT_W+1)'(1)) >= {1'b0, vertex_total};
  assign sts.finishing  = ({1'b0, outer_index} + (CNT_W+1)'(2)) >= {1'b0, vertex_total};

  // pascal row: after n sweeps entry k holds C(n,k)
  always_ff @(posedge clk) begin
    if (cmd.restart) begin
      for (int j = 0; j <= MAX_ELEMENTS; j++) begin
        row[j] <= (j == 0) ? CNT_W'(1) : '0;
      end
      pcnt <= '0;
    end else if (cmd.pascal_step) begin
      for (int j = 1; j <= MAX_ELEMENTS; j++) begin
        row[j] <= row[j] + row[j-1];
      end
      pcnt <= pcnt + kge_pkg::CFG_W'(1);
    end
  end

  // enumeration state
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_n        <= kge_pkg::N_RESET;
      lat_k        <= kge_pkg::K_RESET;
      lat_bad      <= 1'b0;
      vertex_total <= '0;
      finished     <= 1'b1;
      hit          <= 1'b0;
    end else begin
      if (cmd.accept) begin
        hit <= 1'b0;
      end
      if (cmd.restart) begin
        lat_n   <= cfg_n;
        lat_k   <= cfg_k;
        lat_bad <= sts.bad_now;
        if (sts.bad_now) begin
          vertex_total <= '0;
          finished     <= 1'b1;
        end
      end
      if (cmd.pascal_load) begin
        vertex_total <= row_k;
        outer_mask   <= low_k;
        outer_index  <= '0;
        inner_index  <= CNT_W'(1);
        finished     <= (row_k[CNT_W-1:1] == '0) || (lat_k == '0)
                        || ({lat_k, 1'b0} > {1'b0, lat_n});
      end
      if (cmd.init_inner) begin
        inner_mask <= succ_out;
      end
      if (cmd.scan_step) begin
        if (sts.disjoint) begin
          hit   <= 1'b1;
          hit_a <= outer_index;
          hit_b <= inner_index;
        end
        inner_mask  <= succ_out;
        inner_index <= inner_index + CNT_W'(1);
        if (sts.inner_wrap) begin
          outer_index <= outer_index + CNT_W'(1);
          if (sts.finishing) begin
            finished <= 1'b1;
          end
        end
      end
      if (cmd.wrap_outer) begin
        outer_mask <= succ_out;
      end
      if (cmd.wrap_inner) begin
        inner_mask  <= succ_out;
        inner_index <= outer_index + CNT_W'(1);
      end
    end
  end

  assign a_ext     = EXT_W'(hit_a);
  assign b_ext     = EXT_W'(hit_b);
  assign total_ext = EXT_W'(vertex_total);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      first_vertex  <= hit ? a_ext[kge_pkg::OUT_W-1:0] : '0;
      second_vertex <= hit ? b_ext[kge_pkg::OUT_W-1:0] : '0;
      edge_valid    <= hit;
      vertex_count  <= total_ext[kge_pkg::OUT_W-1:0];
      bad_config    <= lat_bad;
    end
  end

endmodule

`default_nettype wire
